/* rtl/pthc_pkg.sv */
// Shared types, constants and helpers for the PTH sensor compensation core.
// Depends on nothing; every other file in rtl imports it.
`default_nettype none
package pthc_pkg;

   typedef logic signed [31:0] s32_type;

   localparam int DIV_STAGES = 32;
   localparam int PRESS_LAT  = 7 + DIV_STAGES + 3;
   localparam int HUM_LAT    = 11;
   localparam int HUM_DELAY  = PRESS_LAT - HUM_LAT;
   localparam int TEMP_DELAY = PRESS_LAT;

   localparam logic [2:0] CSR_TEMP_CAL    = 3'd0;
   localparam logic [2:0] CSR_PRESS_CAL_A = 3'd1;
   localparam logic [2:0] CSR_PRESS_CAL_B = 3'd2;
   localparam logic [2:0] CSR_PRESS_CAL_C = 3'd3;
   localparam logic [2:0] CSR_HUM_CAL_A   = 3'd4;
   localparam logic [2:0] CSR_HUM_CAL_B   = 3'd5;

   typedef struct packed {
      logic [19:0] raw_temp;
      logic [19:0] raw_press;
      logic [15:0] raw_hum;
   } req_type;

   typedef struct packed {
      logic signed [26:0] temperature;
      logic [31:0]        pressure;
      logic               press_div_zero;
      logic [16:0]        humidity;
   } rsp_type;

   typedef struct packed {
      s32_type t1, t2, t3;
      s32_type p1, p2, p3, p4, p5, p6, p7, p8, p9;
      s32_type h1, h2, h3, h4, h5, h6;
   } cal_type;

   typedef struct packed {
      logic        valid;
      s32_type     t_fine;
      logic [19:0] raw_press;
      logic [15:0] raw_hum;
   } tf_type;

   typedef struct packed {
      logic valid;
      logic dz;
      logic post;
   } div_side_type;

   // signed division by 2**k, truncating toward zero
   function automatic s32_type div_trunc(input s32_type x, input int unsigned k);
      s32_type bias;
      bias = x[31] ? s32_type'((33'd1 << k) - 33'd1) : s32_type'(0);
      return (x + bias) >>> k;
   endfunction

endpackage
`default_nettype wire

/* rtl/pthc_temp.sv */
// Fine temperature and temperature pipeline, five register stages.
// Depends on pthc_pkg.
`default_nettype none
module pthc_temp (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   input  wire pthc_pkg::req_type  in_req,
   input  wire pthc_pkg::cal_type  cal,
   output pthc_pkg::tf_type        tf_out,
   output logic signed [26:0]      temp_out
);
   import pthc_pkg::*;

   logic [4:0]  v_ff;
   logic [19:0] rp_ff [5];
   logic [15:0] rh_ff [5];
   s32_type x1_ff, d_ff, m1_ff, dd_ff, a_ff, m2_ff, tf_ff, tf5_ff;
   s32_type adc_t, x1_in, d_in, tf_in, tm_in;
   logic signed [26:0] temp_ff;

   always_comb begin
      adc_t = s32_type'({12'd0, in_req.raw_temp});
      x1_in = (adc_t >>> 3) - (cal.t1 <<< 1);
      d_in  = (adc_t >>> 4) - cal.t1;
      tf_in = a_ff + (m2_ff >>> 14);
      tm_in = tf_ff * 32'sd5 + 32'sd128;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[3:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      x1_ff   <= x1_in;
      d_ff    <= d_in;
      m1_ff   <= x1_ff * cal.t2;
      dd_ff   <= d_ff * d_ff;
      a_ff    <= m1_ff >>> 11;
      m2_ff   <= (dd_ff >>> 12) * cal.t3;
      tf_ff   <= tf_in;
      tf5_ff  <= tf_ff;
      temp_ff <= 27'(tm_in >>> 8);
      rp_ff[0] <= in_req.raw_press;
      rh_ff[0] <= in_req.raw_hum;
      for (int i = 1; i < 5; i++) begin
         rp_ff[i] <= rp_ff[i-1];
         rh_ff[i] <= rh_ff[i-1];
      end
   end

   assign tf_out.valid     = v_ff[4];
   assign tf_out.t_fine    = tf5_ff;
   assign tf_out.raw_press = rp_ff[4];
   assign tf_out.raw_hum   = rh_ff[4];
   assign temp_out         = temp_ff;
endmodule
`default_nettype wire

/* rtl/pthc_div.sv */
// Pipelined restoring divider, one quotient bit per stage, DIV_STAGES stages.
// Depends on pthc_pkg.
`default_nettype none
module pthc_div (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic [31:0]             dividend,
   input  wire logic [31:0]             divisor,
   input  wire pthc_pkg::div_side_type  side_in,
   output logic [31:0]                  quotient,
   output pthc_pkg::div_side_type       side_out
);
   import pthc_pkg::*;

   logic [31:0]  rem_ff  [DIV_STAGES];
   logic [31:0]  dq_ff   [DIV_STAGES];
   logic [31:0]  dvs_ff  [DIV_STAGES];
   div_side_type side_ff [DIV_STAGES];

   logic [31:0]  rem_in [DIV_STAGES];
   logic [31:0]  dq_in  [DIV_STAGES];
   logic [31:0]  dvs_in [DIV_STAGES];

   always_comb begin
      logic [31:0] r, q, s;
      logic [32:0] trial;
      for (int j = 0; j < DIV_STAGES; j++) begin
         r = (j == 0) ? 32'd0 : rem_ff[(j == 0) ? 0 : j-1];
         q = (j == 0) ? dividend : dq_ff[(j == 0) ? 0 : j-1];
         s = (j == 0) ? divisor : dvs_ff[(j == 0) ? 0 : j-1];
         trial = {r, q[31]};
         if (trial >= {1'b0, s}) begin
            rem_in[j] = 32'(trial - {1'b0, s});
            dq_in[j]  = {q[30:0], 1'b1};
         end else begin
            rem_in[j] = trial[31:0];
            dq_in[j]  = {q[30:0], 1'b0};
         end
         dvs_in[j] = s;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < DIV_STAGES; j++) side_ff[j] <= '0;
      end else begin
         side_ff[0] <= side_in;
         for (int j = 1; j < DIV_STAGES; j++) side_ff[j] <= side_ff[j-1];
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < DIV_STAGES; j++) begin
         rem_ff[j] <= rem_in[j];
         dq_ff[j]  <= dq_in[j];
         dvs_ff[j] <= dvs_in[j];
      end
   end

   assign quotient = dq_ff[DIV_STAGES-1];
   assign side_out = side_ff[DIV_STAGES-1];
endmodule
`default_nettype wire

/* rtl/pthc_press.sv */
// Pressure pipeline: seven front stages, the divider, three correction stages.
// Depends on pthc_pkg and pthc_div.
`default_nettype none
module pthc_press (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire pthc_pkg::tf_type   tf_in,
   input  wire pthc_pkg::cal_type  cal,
   output logic                    out_valid,
   output logic [31:0]             out_press,
   output logic                    out_dz
);
   import pthc_pkg::*;

   logic [6:0]  v_ff;
   logic [19:0] rp_ff [4];
   s32_type pa_ff, pq_ff, sq_ff, m5_ff, m2_ff, b6_ff, m3_ff, m5b_ff, m2b_ff;
   s32_type b_ff, a_ff, a2_ff;
   logic [31:0] u_ff, num_ff, dvs_ff, dvd_ff, dvs7_ff;
   logic        dz_ff, dz7_ff, post_ff;
   s32_type pa_in, pq_in, b_in, a_in, bs_in, a3_in;
   logic [31:0] u_in, dvd_in;

   logic [31:0]  quo;
   div_side_type side_in, side_out;

   logic [2:0]  fv_ff;
   logic [2:0]  fdz_ff;
   logic [31:0] pv_ff, pv2_ff, fsq_ff, pout_ff;
   s32_type     pb_ff, fa_ff, fb_ff;
   logic [31:0] pv_in, fs_in, pout_in;
   s32_type     sum_in;

   always_comb begin
      pa_in  = (tf_in.t_fine >>> 1) - 32'sd64000;
      pq_in  = pa_in >>> 2;
      b_in   = ((b6_ff + (m5b_ff <<< 1)) >>> 2) + (cal.p4 <<< 16);
      a_in   = ((m3_ff >>> 3) + (m2b_ff >>> 1)) >>> 18;
      bs_in  = b_ff >>> 12;
      u_in   = 32'd1048576 - {12'd0, rp_ff[3]} - 32'(bs_in);
      a3_in  = a2_ff >>> 15;
      dvd_in = num_ff[31] ? num_ff : {num_ff[30:0], 1'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[5:0], tf_in.valid};
      end
   end

   always_ff @(posedge clock) begin
      rp_ff[0] <= tf_in.raw_press;
      for (int i = 1; i < 4; i++) rp_ff[i] <= rp_ff[i-1];
      pa_ff   <= pa_in;
      pq_ff   <= pq_in;
      sq_ff   <= pq_ff * pq_ff;
      m5_ff   <= pa_ff * cal.p5;
      m2_ff   <= cal.p2 * pa_ff;
      b6_ff   <= (sq_ff >>> 11) * cal.p6;
      m3_ff   <= cal.p3 * (sq_ff >>> 13);
      m5b_ff  <= m5_ff;
      m2b_ff  <= m2_ff;
      b_ff    <= b_in;
      a_ff    <= a_in;
      a2_ff   <= (32'sd32768 + a_ff) * cal.p1;
      u_ff    <= u_in;
      num_ff  <= u_ff * 32'd3125;
      dvs_ff  <= 32'(a3_in);
      dz_ff   <= (a3_in == 32'sd0);
      dvd_ff  <= dvd_in;
      dvs7_ff <= dvs_ff;
      dz7_ff  <= dz_ff;
      post_ff <= num_ff[31];
   end

   assign side_in.valid = v_ff[6];
   assign side_in.dz    = dz7_ff;
   assign side_in.post  = post_ff;

   pthc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .dividend (dvd_ff),
      .divisor  (dvs7_ff),
      .side_in  (side_in),
      .quotient (quo),
      .side_out (side_out)
   );

   always_comb begin
      pv_in   = side_out.post ? {quo[30:0], 1'b0} : quo;
      fs_in   = pv_in >> 3;
      sum_in  = (fa_ff >>> 12) + fb_ff + cal.p7;
      pout_in = pv2_ff + 32'(sum_in >>> 4);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fv_ff <= '0;
      end else begin
         fv_ff <= {fv_ff[1:0], side_out.valid};
      end
   end

   always_ff @(posedge clock) begin
      fdz_ff  <= {fdz_ff[1:0], side_out.dz};
      pv_ff   <= pv_in;
      fsq_ff  <= fs_in * fs_in;
      pb_ff   <= s32_type'(pv_in >> 2) * cal.p8;
      fa_ff   <= cal.p9 * s32_type'(fsq_ff >> 13);
      fb_ff   <= pb_ff >>> 13;
      pv2_ff  <= pv_ff;
      pout_ff <= fdz_ff[1] ? 32'd0 : pout_in;
   end

   assign out_valid = fv_ff[2];
   assign out_press = pout_ff;
   assign out_dz    = fdz_ff[2];
endmodule
`default_nettype wire

/* rtl/pthc_hum.sv */
// Humidity pipeline, HUM_LAT register stages from the fine temperature.
// Depends on pthc_pkg.
`default_nettype none
module pthc_hum (
   input  wire logic               clock,
   input  wire pthc_pkg::tf_type   tf_in,
   input  wire pthc_pkg::cal_type  cal,
   output logic [16:0]             hum_out
);
   import pthc_pkg::*;

   s32_type v1_ff, t_ff, t2_ff, v4_ff, m6_ff, m3_ff;
   s32_type v5_ff [5];
   s32_type v2_ff, v3p_ff, mm_ff, v4b_ff, mh_ff, v2b_ff, v3_ff, v3b_ff, v3c_ff;
   s32_type sq_ff, m_ff;
   logic [16:0] hum_ff;
   s32_type t_in, v5_in, v5f_in, cl_in;

   always_comb begin
      t_in   = s32_type'({2'd0, tf_in.raw_hum, 14'd0}) - (cal.h4 <<< 20);
      v5_in  = div_trunc(t2_ff - v4_ff + 32'sd16384, 15);
      v5f_in = v3c_ff - div_trunc(m_ff, 4);
      if (v5f_in < 0)
         cl_in = 32'sd0;
      else if (v5f_in > 32'sd419430400)
         cl_in = 32'sd419430400;
      else
         cl_in = v5f_in;
   end

   always_ff @(posedge clock) begin
      v1_ff    <= tf_in.t_fine - 32'sd76800;
      t_ff     <= t_in;
      t2_ff    <= t_ff;
      v4_ff    <= cal.h5 * v1_ff;
      m6_ff    <= v1_ff * cal.h6;
      m3_ff    <= v1_ff * cal.h3;
      v5_ff[0] <= v5_in;
      for (int i = 1; i < 5; i++) v5_ff[i] <= v5_ff[i-1];
      v2_ff    <= div_trunc(m6_ff, 10);
      v3p_ff   <= div_trunc(m3_ff, 11) + 32'sd32768;
      mm_ff    <= v2_ff * v3p_ff;
      v4b_ff   <= div_trunc(mm_ff, 10) + 32'sd2097152;
      mh_ff    <= v4b_ff * cal.h2;
      v2b_ff   <= div_trunc(mh_ff + 32'sd8192, 14);
      v3_ff    <= v5_ff[4] * v2b_ff;
      sq_ff    <= div_trunc(v3_ff, 15) * div_trunc(v3_ff, 15);
      v3b_ff   <= v3_ff;
      m_ff     <= div_trunc(sq_ff, 7) * cal.h1;
      v3c_ff   <= v3b_ff;
      hum_ff   <= 17'(cl_in >>> 12);
   end

   assign hum_out = hum_ff;
endmodule
`default_nettype wire

/* rtl/pthc_top_note.sv */
// Calibration register file with decode of the packed calibration words.
// Depends on pthc_pkg.
`default_nettype none
module pthc_csr (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              wr_en,
   input  wire logic [2:0]        wr_index,
   input  wire logic [47:0]       wr_data,
   output pthc_pkg::cal_type      cal
);
   import pthc_pkg::*;

   logic [47:0] temp_cal_ff, pa_ff, pb_ff, pc_ff;
   logic [31:0] ha_ff, hb_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_cal_ff <= '0;
         pa_ff       <= '0;
         pb_ff       <= '0;
         pc_ff       <= '0;
         ha_ff       <= '0;
         hb_ff       <= '0;
      end else if (wr_en) begin
         unique case (wr_index)
            CSR_TEMP_CAL:    temp_cal_ff <= wr_data;
            CSR_PRESS_CAL_A: pa_ff       <= wr_data;
            CSR_PRESS_CAL_B: pb_ff       <= wr_data;
            CSR_PRESS_CAL_C: pc_ff       <= wr_data;
            CSR_HUM_CAL_A:   ha_ff       <= wr_data[31:0];
            CSR_HUM_CAL_B:   hb_ff       <= wr_data[31:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      cal.t1 = {16'd0, temp_cal_ff[15:0]};
      cal.t2 = {{16{temp_cal_ff[31]}}, temp_cal_ff[31:16]};
      cal.t3 = {{16{temp_cal_ff[47]}}, temp_cal_ff[47:32]};
      cal.p1 = {16'd0, pa_ff[15:0]};
      cal.p2 = {{16{pa_ff[31]}}, pa_ff[31:16]};
      cal.p3 = {{16{pa_ff[47]}}, pa_ff[47:32]};
      cal.p4 = {{16{pb_ff[15]}}, pb_ff[15:0]};
      cal.p5 = {{16{pb_ff[31]}}, pb_ff[31:16]};
      cal.p6 = {{16{pb_ff[47]}}, pb_ff[47:32]};
      cal.p7 = {{16{pc_ff[15]}}, pc_ff[15:0]};
      cal.p8 = {{16{pc_ff[31]}}, pc_ff[31:16]};
      cal.p9 = {{16{pc_ff[47]}}, pc_ff[47:32]};
      cal.h1 = {24'd0, ha_ff[7:0]};
      cal.h2 = {{16{ha_ff[23]}}, ha_ff[23:8]};
      cal.h3 = {24'd0, ha_ff[31:24]};
      cal.h4 = {{20{hb_ff[11]}}, hb_ff[11:0]};
      cal.h5 = {{20{hb_ff[23]}}, hb_ff[23:12]};
      cal.h6 = {{24{hb_ff[31]}}, hb_ff[31:24]};
   end
endmodule
`default_nettype wire

/* rtl/pth_sensor_compensation_core.sv */
// PTH sensor compensation core: temperature, pressure and humidity per request.
// From start to rsp_valid: 5 fine-temperature stages, then
// the 42-stage pressure path (32 of them the one-bit-per-stage divider).
// Throughput one request per cycle; busy is always low; the receiver cannot stall.
// Synchronous active-high reset clears valid bits and calibration registers.
// Depends on pthc_pkg, pthc_csr, pthc_temp, pthc_press, pthc_hum.
`default_nettype none
module pth_sensor_compensation_core (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire pthc_pkg::req_type  req_data,
   output logic                    rsp_valid,
   output pthc_pkg::rsp_type       rsp_data,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [2:0]         csr_index,
   input  wire logic [47:0]        csr_wdata
);
   import pthc_pkg::*;

   cal_type            cal;
   tf_type             tf;
   logic signed [26:0] temp;
   logic               p_valid, p_dz;
   logic [31:0]        p_press;
   logic [16:0]        hum;
   logic signed [26:0] td_ff [TEMP_DELAY];
   logic [16:0]        hd_ff [HUM_DELAY];

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   pthc_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid & csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_wdata),
      .cal      (cal)
   );

   pthc_temp u_temp (
      .clock    (clock),
      .reset    (reset),
      .in_valid (start & ~busy),
      .in_req   (req_data),
      .cal      (cal),
      .tf_out   (tf),
      .temp_out (temp)
   );

   pthc_press u_press (
      .clock     (clock),
      .reset     (reset),
      .tf_in     (tf),
      .cal       (cal),
      .out_valid (p_valid),
      .out_press (p_press),
      .out_dz    (p_dz)
   );

   pthc_hum u_hum (
      .clock   (clock),
      .tf_in   (tf),
      .cal     (cal),
      .hum_out (hum)
   );

   // align temperature and humidity with the pressure result
   always_ff @(posedge clock) begin
      td_ff[0] <= temp;
      for (int i = 1; i < TEMP_DELAY; i++) td_ff[i] <= td_ff[i-1];
      hd_ff[0] <= hum;
      for (int i = 1; i < HUM_DELAY; i++) hd_ff[i] <= hd_ff[i-1];
   end

   assign rsp_valid               = p_valid;
   assign rsp_data.temperature    = td_ff[TEMP_DELAY-1];
   assign rsp_data.pressure       = p_press;
   assign rsp_data.press_div_zero = p_dz;
   assign rsp_data.humidity       = hd_ff[HUM_DELAY-1];
endmodule
`default_nettype wire

/* verif/tb.sv */
// Self-checking bench for pth_sensor_compensation_core: directed and random
// reading sets under several calibration settings, checked by a scoreboard.
// Depends on pthc_pkg and the core RTL.
module tb;
   import pthc_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_WAIT  = 60;
   localparam logic [2:0] CSR_SPARE_LO = 3'd6;
   localparam logic [2:0] CSR_SPARE_HI = 3'd7;

   class comp_scoreboard;
      rsp_type     expected_q[$];
      logic [47:0] cal_regs[6];
      int          errors;

      function new();
         errors = 0;
         foreach (cal_regs[i]) cal_regs[i] = '0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [47:0] val);
         if (idx <= CSR_HUM_CAL_B) begin
            cal_regs[idx] = (idx >= CSR_HUM_CAL_A) ? {16'd0, val[31:0]} : val;
         end
      endfunction

      function rsp_type compensate(req_type r);
         rsp_type     res;
         logic [47:0] tc, pa, pb, pc, ha, hb;
         s32_type t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
         s32_type h1, h2, h3, h4, h5, h6;
         s32_type adc_t, adc_h, a, b, d, sh, sh2, t_fine, temp;
         s32_type v1, v2, v3, v4, v5, qa, qb;
         logic [31:0] pu, q, uu;
         logic        dz;
         tc = cal_regs[CSR_TEMP_CAL];    pa = cal_regs[CSR_PRESS_CAL_A];
         pb = cal_regs[CSR_PRESS_CAL_B]; pc = cal_regs[CSR_PRESS_CAL_C];
         ha = cal_regs[CSR_HUM_CAL_A];   hb = cal_regs[CSR_HUM_CAL_B];
         t1 = {16'd0, tc[15:0]}; t2 = $signed(tc[31:16]); t3 = $signed(tc[47:32]);
         p1 = {16'd0, pa[15:0]}; p2 = $signed(pa[31:16]); p3 = $signed(pa[47:32]);
         p4 = $signed(pb[15:0]); p5 = $signed(pb[31:16]); p6 = $signed(pb[47:32]);
         p7 = $signed(pc[15:0]); p8 = $signed(pc[31:16]); p9 = $signed(pc[47:32]);
         h1 = {24'd0, ha[7:0]};  h2 = $signed(ha[23:8]);  h3 = {24'd0, ha[31:24]};
         h4 = $signed(hb[11:0]); h5 = $signed(hb[23:12]); h6 = $signed(hb[31:24]);
         adc_t = {12'd0, r.raw_temp};
         adc_h = {16'd0, r.raw_hum};

         // fine temperature: second term squares (adc/16 - T1)
         sh = adc_t >>> 3;
         a = (sh - t1 * 2) * t2;
         a = a >>> 11;
         sh = adc_t >>> 4;
         d = sh - t1;
         b = d * d;
         b = b >>> 12;
         b = b * t3;
         b = b >>> 14;
         t_fine = a + b;
         temp = t_fine * 5 + 128;
         temp = temp >>> 8;

         // pressure
         sh = t_fine >>> 1;
         a = sh - 64000;
         sh = a >>> 2;
         d = sh * sh;
         d = d >>> 11;
         b = d * p6;
         b = b + a * p5 * 2;
         b = b >>> 2;
         b = b + p4 * 65536;
         d = sh * sh;
         d = d >>> 13;
         qa = p3 * d;
         qa = qa >>> 3;
         qb = p2 * a;
         qb = qb >>> 1;
         a = qa + qb;
         a = a >>> 18;
         a = (32768 + a) * p1;
         a = a >>> 15;
         dz = (a == 0);
         if (dz) begin
            pu = '0;
         end else begin
            sh2 = b >>> 12;
            pu = (32'd1048576 - {12'd0, r.raw_press} - sh2) * 32'd3125;
            q = a;
            if (pu < 32'h8000_0000) pu = (pu << 1) / q;
            else pu = (pu / q) * 32'd2;
            uu = (pu >> 3) * (pu >> 3);
            uu = uu >> 13;
            qa = uu;
            qa = p9 * qa;
            qa = qa >>> 12;
            qb = pu >> 2;
            qb = qb * p8;
            qb = qb >>> 13;
            sh2 = qa + qb + p7;
            sh2 = sh2 >>> 4;
            pu = pu + sh2;
         end

         // humidity, signed divisions truncate toward zero
         v1 = t_fine - 76800;
         v2 = adc_h * 16384;
         v3 = h4 * 1048576;
         v4 = h5 * v1;
         v5 = v2 - v3 - v4 + 16384;
         v5 = v5 / 32768;
         v2 = v1 * h6;
         v2 = v2 / 1024;
         v3 = v1 * h3;
         v3 = v3 / 2048;
         v4 = v2 * (v3 + 32768);
         v4 = v4 / 1024 + 2097152;
         v2 = v4 * h2 + 8192;
         v2 = v2 / 16384;
         v3 = v5 * v2;
         v4 = v3 / 32768;
         v4 = v4 * v4;
         v4 = v4 / 128;
         v2 = v4 * h1;
         v2 = v2 / 16;
         v5 = v3 - v2;
         if (v5 < 0) v5 = 0;
         if (v5 > 419430400) v5 = 419430400;
         v5 = v5 / 4096;

         res.temperature    = temp[26:0];
         res.pressure       = pu;
         res.press_div_zero = dz;
         res.humidity       = v5[16:0];
         return res;
      endfunction

      function void note_request(req_type r);
         expected_q.push_back(compensate(r));
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (expected_q.size() == 0) begin
            $display("%0t unexpected result %h", $time, got);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         if (got.temperature !== want.temperature) begin
            $display("%0t temperature exp %0d got %0d", $time, want.temperature,
                     got.temperature);
            errors++;
         end
         if (got.pressure !== want.pressure) begin
            $display("%0t pressure exp %0d got %0d", $time, want.pressure, got.pressure);
            errors++;
         end
         if (got.press_div_zero !== want.press_div_zero) begin
            $display("%0t press_div_zero exp %0b got %0b", $time, want.press_div_zero,
                     got.press_div_zero);
            errors++;
         end
         if (got.humidity !== want.humidity) begin
            $display("%0t humidity exp %0d got %0d", $time, want.humidity, got.humidity);
            errors++;
         end
      endfunction
   endclass

   logic        clock, reset, start, busy, rsp_valid, csr_valid, csr_ready;
   req_type     req_data;
   rsp_type     rsp_data;
   logic [2:0]  csr_index;
   logic [47:0] csr_wdata;
   int          cycles = 0;
   bit          allow_idle;

   comp_scoreboard sb = new();

   pth_sensor_compensation_core dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      clock = 1'b1; #1;
      clock = 1'b0; #1;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.check_result(rsp_data);
   end

   task automatic send_request(req_type r);
      if (allow_idle && $urandom_range(0, 5) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      sb.note_request(r);
   endtask

   // leaves csr_valid high; the caller drops it after the last write
   task automatic write_csr(logic [2:0] idx, logic [47:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, val);
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   function automatic logic [47:0] rand48();
      return {16'($urandom), 32'($urandom)};
   endfunction

   function automatic logic [15:0] jitter(int base, int span);
      return 16'(base + $signed($urandom_range(0, 2 * span)) - span);
   endfunction

   // calibration set: 0 typical, 1 random, 2 all ones, 3 max positive, 4 min negative
   task automatic load_cal(int kind);
      logic [47:0] w[6];
      case (kind)
         0: begin
            w[0] = {jitter(-1000, 300), jitter(26435, 2000), jitter(27504, 2000)};
            w[1] = {jitter(3024, 500), jitter(-10685, 1000), jitter(36477, 3000)};
            w[2] = {jitter(-7, 5), jitter(140, 50), jitter(2855, 500)};
            w[3] = {jitter(6000, 500), jitter(-14600, 1000), jitter(15500, 1000)};
            w[4] = {16'd0, 8'($urandom_range(0, 40)), jitter(370, 50),
                    8'($urandom_range(60, 90))};
            w[5] = {16'd0, 8'($urandom_range(20, 40)), 12'($urandom_range(40, 60)),
                    12'($urandom_range(280, 340))};
         end
         1: foreach (w[i]) w[i] = rand48();
         2: foreach (w[i]) w[i] = '1;
         3: begin
            w[0] = {16'h7FFF, 16'h7FFF, 16'hFFFF};
            w[1] = {16'h7FFF, 16'h7FFF, 16'hFFFF};
            w[2] = {3{16'h7FFF}};
            w[3] = {3{16'h7FFF}};
            w[4] = {16'd0, 8'hFF, 16'h7FFF, 8'hFF};
            w[5] = {16'd0, 8'h7F, 12'h7FF, 12'h7FF};
         end
         default: begin
            w[0] = {16'h8000, 16'h8000, 16'h0000};
            w[1] = {16'h8000, 16'h8000, 16'h0001};
            w[2] = {3{16'h8000}};
            w[3] = {3{16'h8000}};
            w[4] = {16'd0, 8'h00, 16'h8000, 8'h00};
            w[5] = {16'd0, 8'h80, 12'h800, 12'h800};
         end
      endcase
      write_csr(CSR_TEMP_CAL, w[0]);
      write_csr(CSR_PRESS_CAL_A, w[1]);
      write_csr(CSR_PRESS_CAL_B, w[2]);
      write_csr(CSR_PRESS_CAL_C, w[3]);
      write_csr(CSR_HUM_CAL_A, w[4]);
      write_csr(CSR_HUM_CAL_B, w[5]);
      // unmapped indexes must leave the calibration untouched
      write_csr(CSR_SPARE_LO, rand48());
      write_csr(CSR_SPARE_HI, rand48());
      csr_valid <= 1'b0;
   endtask

   function automatic req_type rand_request(bit typical);
      req_type r;
      if (typical) begin
         r.raw_temp  = 20'(519888 + $urandom_range(0, 200000) - 100000);
         r.raw_press = 20'(415148 + $urandom_range(0, 200000) - 100000);
         r.raw_hum   = 16'($urandom_range(10000, 50000));
      end else begin
         r.raw_temp  = 20'($urandom);
         r.raw_press = 20'($urandom);
         r.raw_hum   = 16'($urandom);
      end
      return r;
   endfunction

   task automatic directed_set();
      send_request('{raw_temp: 20'd0, raw_press: 20'd0, raw_hum: 16'd0});
      send_request('{raw_temp: 20'hFFFFF, raw_press: 20'hFFFFF, raw_hum: 16'hFFFF});
      send_request('{raw_temp: 20'd0, raw_press: 20'hFFFFF, raw_hum: 16'd0});
      send_request('{raw_temp: 20'hFFFFF, raw_press: 20'd0, raw_hum: 16'hFFFF});
      send_request('{raw_temp: 20'h80000, raw_press: 20'h80000, raw_hum: 16'h8000});
      send_request('{raw_temp: 20'd519888, raw_press: 20'd415148, raw_hum: 16'd30000});
      send_request('{raw_temp: 20'h7FFFF, raw_press: 20'h7FFFF, raw_hum: 16'h7FFF});
      send_request('{raw_temp: 20'd1, raw_press: 20'd1, raw_hum: 16'd1});
   endtask

   initial begin
      reset      <= 1'b1;
      start      <= 1'b0;
      req_data   <= '0;
      csr_valid  <= 1'b0;
      csr_index  <= CSR_TEMP_CAL;
      csr_wdata  <= '0;
      allow_idle = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero calibration after reset: divisor is zero
      directed_set();
      wait_drained();
      load_cal(0);
      directed_set();
      wait_drained();
      load_cal(3);
      directed_set();
      wait_drained();
      load_cal(4);
      send_request('{raw_temp: 20'hFFFFF, raw_press: 20'd0, raw_hum: 16'hFFFF});
      send_request('{raw_temp: 20'd0, raw_press: 20'hFFFFF, raw_hum: 16'd0});
      wait_drained();

      allow_idle = 1'b1;
      for (int ph = 0; ph < 8; ph++) begin
         load_cal((ph < 3) ? 0 : ph % 5);
         // no idling in the last phase
         if (ph == 7) allow_idle = 1'b0;
         for (int n = 0; n < 244; n++) begin
            send_request(rand_request($urandom_range(0, 3) != 0));
         end
         wait_drained();
      end

      if (sb.errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
